// File: design/amcd_pkg.sv
// shared types and constants for the avi movi chunk demux
package amcd_pkg;

	localparam int unsigned PADDR_W = 3;

	localparam logic [PADDR_W-1:0] REG_MAX_CHUNK_BYTES = PADDR_W'(0);

	localparam logic [31:0] MAX_CHUNK_RESET = 32'd10485760;

	localparam logic [31:0] TAG_MOVI = 32'h6D6F7669;
	localparam logic [31:0] TAG_00DC = 32'h30306463;
	localparam logic [31:0] TAG_00DB = 32'h30306462;

	localparam logic [3:0] HDR_BYTES = 4'd8;
	localparam logic [3:0] HDR_SLIDE = 4'd7;

	typedef enum logic [1:0] {
		MODE_SEARCH,
		MODE_HEADER,
		MODE_PAYLOAD,
		MODE_PAD
	} mode_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
		logic       frame_truncated;
		logic       frame_uncompressed_id;
	} res_t;

endpackage

// File: design/amcd_ifs.sv
// stream channel interfaces for the avi movi chunk demux
interface amcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_start, output stream_end,
		input ready);
	modport sink (input valid, input data_byte, input stream_start, input stream_end,
		output ready);
endinterface

interface amcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;
	logic       frame_truncated;
	logic       frame_uncompressed_id;

	modport source (output valid, output frame_byte, output frame_last,
		output frame_truncated, output frame_uncompressed_id, input ready);
	modport sink (input valid, input frame_byte, input frame_last,
		input frame_truncated, input frame_uncompressed_id, output ready);
endinterface

// File: design/amcd_parse.sv
// chunk parser: movi hunt, header window, payload count and pad skip
module amcd_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               stream_start,
	input  logic               stream_end,
	input  logic [31:0]        max_chunk_bytes,
	output logic               res_valid,
	output amcd_pkg::res_t     res
);

	amcd_pkg::mode_t mode_q, mode_c, mode_n;
	logic [63:0] win_q, win_c, win_n, win_sh;
	logic [3:0]  fill_q, fill_c, fill_n, fill_inc;
	logic [31:0] left_q, left_c, left_n, size;
	logic        vid_q, vid_c, vid_n;
	logic        db_q, db_c, db_n;
	logic        pad_q, pad_c, pad_n;
	logic        done;

	always_comb begin
		mode_c = stream_start ? amcd_pkg::MODE_SEARCH : mode_q;
		win_c  = stream_start ? 64'd0 : win_q;
		fill_c = stream_start ? 4'd0 : fill_q;
		left_c = stream_start ? 32'd0 : left_q;
		vid_c  = stream_start ? 1'b0 : vid_q;
		db_c   = stream_start ? 1'b0 : db_q;
		pad_c  = stream_start ? 1'b0 : pad_q;

		win_sh   = {win_c[55:0], data_byte};
		fill_inc = fill_c + 4'd1;
		size     = {win_sh[7:0], win_sh[15:8], win_sh[23:16], win_sh[31:24]};
		left_n   = (left_c != 32'd0) ? left_c - 32'd1 : 32'd0;
		done     = (left_n == 32'd0);

		mode_n = mode_c;
		win_n  = win_c;
		fill_n = fill_c;
		vid_n  = vid_c;
		db_n   = db_c;
		pad_n  = pad_c;

		res_valid                 = 1'b0;
		res.frame_byte            = data_byte;
		res.frame_last            = done | stream_end;
		res.frame_truncated       = stream_end & ~done;
		res.frame_uncompressed_id = db_c;

		case (mode_c)
			amcd_pkg::MODE_SEARCH: begin
				win_n = win_sh;
				if (win_sh[31:0] == amcd_pkg::TAG_MOVI) begin
					mode_n = amcd_pkg::MODE_HEADER;
					win_n  = 64'd0;
					fill_n = 4'd0;
				end
			end
			amcd_pkg::MODE_HEADER: begin
				win_n  = win_sh;
				fill_n = fill_inc;
				if (fill_inc >= amcd_pkg::HDR_BYTES) begin
					if (size == 32'd0 || size > max_chunk_bytes) begin
						fill_n = amcd_pkg::HDR_SLIDE;
					end else begin
						vid_n  = (win_sh[63:32] == amcd_pkg::TAG_00DC) ||
							(win_sh[63:32] == amcd_pkg::TAG_00DB);
						db_n   = (win_sh[63:32] == amcd_pkg::TAG_00DB);
						pad_n  = size[0];
						fill_n = 4'd0;
						mode_n = amcd_pkg::MODE_PAYLOAD;
					end
				end
			end
			amcd_pkg::MODE_PAYLOAD: begin
				res_valid = vid_c;
				if (done) begin
					mode_n = pad_c ? amcd_pkg::MODE_PAD : amcd_pkg::MODE_HEADER;
					win_n  = 64'd0;
					fill_n = 4'd0;
				end
			end
			default: begin
				mode_n = amcd_pkg::MODE_HEADER;
				pad_n  = 1'b0;
				win_n  = 64'd0;
				fill_n = 4'd0;
			end
		endcase

		if (stream_end) begin
			mode_n = amcd_pkg::MODE_SEARCH;
			win_n  = 64'd0;
			fill_n = 4'd0;
			vid_n  = 1'b0;
			db_n   = 1'b0;
			pad_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= amcd_pkg::MODE_SEARCH;
			win_q  <= 64'd0;
			fill_q <= 4'd0;
			left_q <= 32'd0;
			vid_q  <= 1'b0;
			db_q   <= 1'b0;
			pad_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			win_q  <= win_n;
			fill_q <= fill_n;
			vid_q  <= vid_n;
			db_q   <= db_n;
			pad_q  <= pad_n;
			if (stream_end)
				left_q <= 32'd0;
			else if (mode_c == amcd_pkg::MODE_HEADER && mode_n == amcd_pkg::MODE_PAYLOAD)
				left_q <= size;
			else if (mode_c == amcd_pkg::MODE_PAYLOAD)
				left_q <= left_n;
			else
				left_q <= left_c;
		end
	end

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == amcd_pkg::MODE_PAYLOAD |-> left_q != 32'd0)
		else $error("payload mode with nothing left");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < amcd_pkg::HDR_BYTES)
		else $error("header fill out of range");

	a_search_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == amcd_pkg::MODE_SEARCH |-> fill_q == 4'd0 && left_q == 32'd0 && !pad_q)
		else $error("stale chunk state during movi hunt");

endmodule

// File: design/avi_movi_chunk_demux.sv
// avi movi chunk demux top level: apb register, parser and output word buffer
// One byte word is taken per cycle while the output side keeps up; its frame word, if any,
// is registered in the output register, or in the one-entry skid buffer behind it, which
// absorbs one stalled word, so input pauses only when both are full. max_chunk_bytes sits
// at byte address 0 of the apb port; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module avi_movi_chunk_demux (
	input  logic                          clk,
	input  logic                          arst_n,
	amcd_in_if.sink                       in_ch,
	amcd_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [amcd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [31:0]    max_q;
	logic           step;
	logic           res_valid;
	amcd_pkg::res_t res;
	logic           out_valid_q, skid_valid_q, pop, push;
	amcd_pkg::res_t out_q, skid_q;

	assign pready = 1'b1;
	assign prdata = (paddr == amcd_pkg::REG_MAX_CHUNK_BYTES) ? max_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= amcd_pkg::MAX_CHUNK_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr == amcd_pkg::REG_MAX_CHUNK_BYTES) begin
			max_q <= pwdata;
		end
	end

	assign in_ch.ready = !skid_valid_q;
	assign step        = in_ch.valid && in_ch.ready;

	amcd_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (in_ch.data_byte),
		.stream_start    (in_ch.stream_start),
		.stream_end      (in_ch.stream_end),
		.max_chunk_bytes (max_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	assign pop  = out_valid_q && out_ch.ready;
	assign push = step && res_valid;

	// output word register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push && out_valid_q && !pop) begin
			skid_valid_q <= 1'b1;
		end else begin
			out_valid_q <= push || (out_valid_q && !pop);
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push && out_valid_q && !pop) begin
			skid_q <= res;
		end else if (push) begin
			out_q <= res;
		end
	end

	assign out_ch.valid                 = out_valid_q;
	assign out_ch.frame_byte            = out_q.frame_byte;
	assign out_ch.frame_last            = out_q.frame_last;
	assign out_ch.frame_truncated       = out_q.frame_truncated;
	assign out_ch.frame_uncompressed_id = out_q.frame_uncompressed_id;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word without output word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && !pop |=> skid_valid_q && out_valid_q)
		else $error("word lost while output stalled");

	a_skid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q)
		else $error("skid word not moved on pop");

endmodule
